### hdl/cdc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cdc_pkg
// Shared types, constants, microcode store and calendar functions for the date counter.
// ----------------------------------------------------------------------------
package cdc_pkg;

  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned YearW  = 12;
  localparam int unsigned CountW = 16;
  localparam int unsigned StatW  = 3;
  localparam int unsigned StepW  = 3;

  localparam logic [YearW-1:0]  YearMin  = 12'd1900;
  localparam logic [YearW-1:0]  YearMax  = 12'd2100;
  localparam logic [YearW-1:0]  YearTop  = 12'd4095;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [DayW-1:0]   DayLast  = 5'd31;
  localparam logic [DayW-1:0]   DayLeap  = 5'd29;
  localparam int unsigned       NumCent  = 41;

  typedef enum logic [StatW-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_MONTH = 3'd1,
    ST_BAD_YEAR  = 3'd2,
    ST_BAD_DAY   = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ACT_NOP,
    ACT_TAKE,
    ACT_CHECK,
    ACT_STEP,
    ACT_EMIT
  } act_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_IS_LOAD,
    C_CNT_ZERO,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    act_t             act;
    cond_t            cond;
    logic [StepW-1:0] target;
  } uword_t;

  typedef struct packed {
    logic is_load;
    logic cnt_zero;
    logic out_busy;
  } dp_flags_t;

  localparam logic [StepW-1:0] SWait  = 3'd0;
  localparam logic [StepW-1:0] SDisp  = 3'd1;
  localparam logic [StepW-1:0] STest  = 3'd2;
  localparam logic [StepW-1:0] SStep  = 3'd3;
  localparam logic [StepW-1:0] SSpare = 3'd4;
  localparam logic [StepW-1:0] SSpar2 = 3'd5;
  localparam logic [StepW-1:0] SCheck = 3'd6;
  localparam logic [StepW-1:0] SEmit  = 3'd7;

  function automatic uword_t ucode(input logic [StepW-1:0] step);
    uword_t w;
    unique case (step)
      SWait:   w = '{act: ACT_TAKE,  cond: C_NO_INPUT, target: SWait};
      SDisp:   w = '{act: ACT_NOP,   cond: C_IS_LOAD,  target: SCheck};
      STest:   w = '{act: ACT_NOP,   cond: C_CNT_ZERO, target: SEmit};
      SStep:   w = '{act: ACT_STEP,  cond: C_ALWAYS,   target: STest};
      SSpare:  w = '{act: ACT_NOP,   cond: C_ALWAYS,   target: SWait};
      SSpar2:  w = '{act: ACT_NOP,   cond: C_ALWAYS,   target: SWait};
      SCheck:  w = '{act: ACT_CHECK, cond: C_NEVER,    target: SWait};
      SEmit:   w = '{act: ACT_EMIT,  cond: C_OUT_BUSY, target: SEmit};
      default: w = '{act: ACT_NOP,   cond: C_ALWAYS,   target: SWait};
    endcase
    return w;
  endfunction

  function automatic logic is_leap(input logic [YearW-1:0] y);
    logic cent;
    logic quad;
    cent = 1'b0;
    quad = 1'b0;
    for (int k = 0; k < NumCent; k++) begin
      if (y == YearW'(k * 100)) begin
        cent = 1'b1;
        quad = ((k % 4) == 0);
      end
    end
    return (y[1:0] == 2'b00) && (!cent || quad);
  endfunction

  function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] m,
                                                 input logic              leap);
    logic [DayW-1:0] d;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
      4'd2:                                       d = leap ? 5'd29 : 5'd28;
      default:                                    d = 5'd0;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

### hdl/calendar_date_counter.sv
`default_nettype none
// A load is taken, dispatched, checked and emitted. An advance is taken, dispatched,
// then loops through a test step and a step action, one day per pass, until the day
// count is zero (ended early when the year overflows), and is then emitted.
// Throughput: one transaction at a time; the next is taken once the result is in the
// output register, which may still wait on out_tready.
// Reset: synchronous, active low; the date returns to 1 January 1900.
// ----------------------------------------------------------------------------
// calendar_date_counter
// Gregorian date register with checked load and day-count advance.
// ----------------------------------------------------------------------------
module calendar_date_counter
  import cdc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // month_in[3:0], day_in[8:4], year_in[20:9],
                                       // day_count[36:21], zero pad [39:37]
  input  wire logic        in_tuser,   // op
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata   // month_out[3:0], day_out[8:4], year_out[20:9],
                                       // status[23:21], is_feb29[24], zero pad [31:25]
);

  act_t              act;
  dp_flags_t         flags;
  logic [MonthW-1:0] month_out;
  logic [DayW-1:0]   day_out;
  logic [YearW-1:0]  year_out;
  logic [StatW-1:0]  status;
  logic              is_feb29;

  assign in_tready = (act == ACT_TAKE);

  cdc_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .flags    (flags),
    .act      (act)
  );

  cdc_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .act       (act),
    .op        (in_tuser),
    .month_in  (in_tdata[3:0]),
    .day_in    (in_tdata[8:4]),
    .year_in   (in_tdata[20:9]),
    .day_count (in_tdata[36:21]),
    .out_ready (out_tready),
    .flags     (flags),
    .out_valid (out_tvalid),
    .month_out (month_out),
    .day_out   (day_out),
    .year_out  (year_out),
    .status    (status),
    .is_feb29  (is_feb29)
  );

  assign out_tdata = {7'd0, is_feb29, status, year_out, day_out, month_out};

endmodule
`default_nettype wire

### hdl/cdc_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cdc_seq
// Microcode sequencer: step counter, control store and jump logic.
// ----------------------------------------------------------------------------
module cdc_seq
  import cdc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire dp_flags_t flags,
  output act_t           act
);

  logic [StepW-1:0] step_r;
  logic [StepW-1:0] step_nxt;
  uword_t           uw;
  logic             taken;

  assign uw  = ucode(step_r);
  assign act = uw.act;

  always_comb begin
    unique case (uw.cond)
      C_NEVER:    taken = 1'b0;
      C_ALWAYS:   taken = 1'b1;
      C_NO_INPUT: taken = !in_valid;
      C_IS_LOAD:  taken = flags.is_load;
      C_CNT_ZERO: taken = flags.cnt_zero;
      C_OUT_BUSY: taken = flags.out_busy;
      default:    taken = 1'b0;
    endcase
  end

  always_comb begin
    step_nxt = taken ? uw.target : step_r + StepW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= SWait;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule
`default_nettype wire

### hdl/cdc_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cdc_dpath
// Date datapath: held date, operand latches, day counter and result register.
// ----------------------------------------------------------------------------
module cdc_dpath
  import cdc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire act_t              act,
  input  wire logic              op,
  input  wire logic [MonthW-1:0] month_in,
  input  wire logic [DayW-1:0]   day_in,
  input  wire logic [YearW-1:0]  year_in,
  input  wire logic [CountW-1:0] day_count,
  input  wire logic              out_ready,
  output dp_flags_t              flags,
  output logic                   out_valid,
  output logic [MonthW-1:0]      month_out,
  output logic [DayW-1:0]        day_out,
  output logic [YearW-1:0]       year_out,
  output logic [StatW-1:0]       status,
  output logic                   is_feb29
);

  logic [MonthW-1:0] cur_month_r, cur_month_nxt;
  logic [DayW-1:0]   cur_day_r,   cur_day_nxt;
  logic [YearW-1:0]  cur_year_r,  cur_year_nxt;
  logic              op_r;
  logic [MonthW-1:0] m_r;
  logic [DayW-1:0]   d_r;
  logic [YearW-1:0]  y_r;
  logic [CountW-1:0] cnt_r,  cnt_nxt;
  status_t           stat_r, stat_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [MonthW-1:0] om_r;
  logic [DayW-1:0]   od_r;
  logic [YearW-1:0]  oy_r;
  logic [StatW-1:0]  os_r;
  logic              of_r;
  logic              out_busy;
  logic              emit;
  logic [DayW-1:0]   load_len;
  logic [DayW-1:0]   cur_len;
  logic              at_end;

  assign out_busy = out_valid_r && !out_ready;
  assign emit     = (act == ACT_EMIT) && !out_busy;
  assign load_len = month_days(m_r, is_leap(y_r));
  assign cur_len  = month_days(cur_month_r, is_leap(cur_year_r));
  assign at_end   = (cur_month_r == MonthDec) && (cur_day_r == DayLast) &&
                    (cur_year_r == YearTop);

  assign flags = '{is_load: !op_r, cnt_zero: (cnt_r == '0), out_busy: out_busy};

  always_comb begin
    cur_month_nxt = cur_month_r;
    cur_day_nxt   = cur_day_r;
    cur_year_nxt  = cur_year_r;
    cnt_nxt       = cnt_r;
    stat_nxt      = stat_r;
    unique case (act)
      ACT_TAKE: begin
        cnt_nxt  = day_count;
        stat_nxt = ST_OK;
      end
      ACT_CHECK: begin
        priority if (m_r < 4'd1 || m_r > MonthDec) begin
          stat_nxt = ST_BAD_MONTH;
        end else if (y_r < YearMin || y_r > YearMax) begin
          stat_nxt = ST_BAD_YEAR;
        end else if (d_r < 5'd1 || d_r > load_len) begin
          stat_nxt = ST_BAD_DAY;
        end else begin
          cur_month_nxt = m_r;
          cur_day_nxt   = d_r;
          cur_year_nxt  = y_r;
        end
      end
      ACT_STEP: begin
        priority if (at_end) begin
          stat_nxt = ST_OVERFLOW;
          cnt_nxt  = '0;
        end else if (cur_day_r < cur_len) begin
          cur_day_nxt = cur_day_r + DayW'(1);
          cnt_nxt     = cnt_r - CountW'(1);
        end else if (cur_month_r < MonthDec) begin
          cur_month_nxt = cur_month_r + MonthW'(1);
          cur_day_nxt   = DayW'(1);
          cnt_nxt       = cnt_r - CountW'(1);
        end else begin
          cur_year_nxt  = cur_year_r + YearW'(1);
          cur_month_nxt = MonthW'(1);
          cur_day_nxt   = DayW'(1);
          cnt_nxt       = cnt_r - CountW'(1);
        end
      end
      ACT_NOP, ACT_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_month_r <= MonthW'(1);
      cur_day_r   <= DayW'(1);
      cur_year_r  <= YearMin;
      out_valid_r <= 1'b0;
      stat_r      <= ST_OK;
      cnt_r       <= '0;
      op_r        <= 1'b0;
    end else begin
      cur_month_r <= cur_month_nxt;
      cur_day_r   <= cur_day_nxt;
      cur_year_r  <= cur_year_nxt;
      out_valid_r <= out_valid_nxt;
      stat_r      <= stat_nxt;
      cnt_r       <= cnt_nxt;
      if (act == ACT_TAKE) begin
        op_r <= op;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (act == ACT_TAKE) begin
      m_r <= month_in;
      d_r <= day_in;
      y_r <= year_in;
    end
    if (emit) begin
      om_r <= cur_month_r;
      od_r <= cur_day_r;
      oy_r <= cur_year_r;
      os_r <= stat_r;
      of_r <= (cur_month_r == MonthFeb) && (cur_day_r == DayLeap);
    end
  end

  assign out_valid = out_valid_r;
  assign month_out = om_r;
  assign day_out   = od_r;
  assign year_out  = oy_r;
  assign status    = os_r;
  assign is_feb29  = of_r;

endmodule
`default_nettype wire

### verif/calendar_date_counter_tb.sv
// ----------------------------------------------------------------------------
// calendar_date_counter_tb
// Drives load and advance transactions into the date counter with random idle
// time on both stream sides. A scoreboard keeps its own copy of the date,
// predicts the date, status and 29-February flag of every transaction, and
// compares each result field by field.
// ----------------------------------------------------------------------------
module calendar_date_counter_tb;
  import cdc_pkg::*;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;
  localparam int   RANDOM_ITEMS = 1175;

  typedef struct packed {
    logic [CountW-1:0] count;
    logic [YearW-1:0]  year;
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
  } date_req_t;

  typedef struct packed {
    logic              feb29;
    status_t           status;
    logic [YearW-1:0]  year;
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
  } date_res_t;

  class date_scoreboard;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [YearW-1:0]  year;
    date_res_t         awaited[$];
    int unsigned       errors;
    int unsigned       loads;
    int unsigned       rejects;
    int unsigned       advances;
    int unsigned       overflows;
    int unsigned       feb29_seen;
    longint unsigned   days_stepped;

    function new();
      month        = 4'd1;
      day          = 5'd1;
      year         = YearMin;
      errors       = 0;
      loads        = 0;
      rejects      = 0;
      advances     = 0;
      overflows    = 0;
      feb29_seen   = 0;
      days_stepped = 0;
    endfunction

    static function logic leap_year(logic [YearW-1:0] y);
      return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    endfunction

    static function logic [DayW-1:0] month_length(logic [MonthW-1:0] m,
                                                  logic [YearW-1:0]  y);
      logic [DayW-1:0] len;
      case (m)
        4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
        MonthFeb:                                   len = leap_year(y) ? DayLeap : 5'd28;
        4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DayLast;
        default:                                    len = 5'd0;
      endcase
      return len;
    endfunction

    function logic advance_one_day();
      if (day < month_length(month, year)) begin
        day++;
      end else if (month < MonthDec) begin
        month++;
        day = 5'd1;
      end else if (year == YearTop) begin
        return 1'b0;
      end else begin
        year++;
        month = 4'd1;
        day   = 5'd1;
      end
      return 1'b1;
    endfunction

    function void note_request(logic op, date_req_t r);
      date_res_t e;
      status_t   st;
      st = ST_OK;
      if (op == OP_LOAD) begin
        loads++;
        if (r.month < 1 || r.month > MonthDec) begin
          st = ST_BAD_MONTH;
        end else if (r.year < YearMin || r.year > YearMax) begin
          st = ST_BAD_YEAR;
        end else if (r.day < 1 || r.day > month_length(r.month, r.year)) begin
          st = ST_BAD_DAY;
        end else begin
          month = r.month;
          day   = r.day;
          year  = r.year;
        end
        if (st != ST_OK) rejects++;
      end else begin
        advances++;
        for (int i = 0; i < r.count; i++) begin
          if (!advance_one_day()) begin
            st = ST_OVERFLOW;
            overflows++;
            break;
          end
          days_stepped++;
        end
      end
      e.month  = month;
      e.day    = day;
      e.year   = year;
      e.status = st;
      e.feb29  = (month == MonthFeb) && (day == DayLeap);
      if (e.feb29) feb29_seen++;
      awaited.push_back(e);
    endfunction

    function void check_reply(date_res_t got);
      date_res_t e;
      if (awaited.size() == 0) begin
        $error("result with no transaction pending: %0d-%0d-%0d status %0d",
               got.year, got.month, got.day, got.status);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (got.month !== e.month) begin
        $error("month_out: expected %0d, got %0d", e.month, got.month);
        errors++;
      end
      if (got.day !== e.day) begin
        $error("day_out: expected %0d, got %0d", e.day, got.day);
        errors++;
      end
      if (got.year !== e.year) begin
        $error("year_out: expected %0d, got %0d", e.year, got.year);
        errors++;
      end
      if (got.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, got.status);
        errors++;
      end
      if (got.feb29 !== e.feb29) begin
        $error("is_feb29: expected %0d, got %0d", e.feb29, got.feb29);
        errors++;
      end
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;   // month_in[3:0], day_in[8:4], year_in[20:9],
                                  // day_count[36:21], zero pad [39:37]
  logic        in_tuser   = 1'b0; // op
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // month_out[3:0], day_out[8:4], year_out[20:9],
                                  // status[23:21], is_feb29[24], zero pad [31:25]

  date_scoreboard  sb;
  longint unsigned cycle_count  = 0;
  longint unsigned cycle_budget = 0;
  int              in_calm      = 0;
  int              out_calm     = 0;

  calendar_date_counter uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // hold idle at zero for a stretch now and then
  function automatic int idle_cycles(inout int calm);
    int gap;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    gap = $urandom_range(0, 12);
    if ($urandom_range(0, 15) == 0) calm = $urandom_range(4, 30);
    return gap;
  endfunction

  task automatic push_date(input logic op, input logic [MonthW-1:0] m,
                           input logic [DayW-1:0] d, input logic [YearW-1:0] y,
                           input logic [CountW-1:0] n);
    int        gap;
    date_req_t r;
    gap = idle_cycles(in_calm);
    r   = '{count: n, year: y, day: d, month: m};
    cycle_budget += (op == OP_ADVANCE) ? 2 * longint'(n) + 64 : 64;
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = {3'b000, r};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      sb.note_request(in_tuser, date_req_t'(in_tdata[36:0]));
    if (rst_n && out_tvalid && out_tready)
      sb.check_reply(date_res_t'(out_tdata[24:0]));
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 4 * cycle_budget + 50000) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : result_sink
    int gap;
    wait (rst_n);
    @(negedge clk);
    forever begin
      gap = idle_cycles(out_calm);
      if (gap > 0) begin
        out_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready = 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int                sel;
    int                pick;
    logic [MonthW-1:0] m;
    logic [DayW-1:0]   d;
    logic [YearW-1:0]  y;
    logic [CountW-1:0] n;
    logic [DayW-1:0]   len;
    sb = new();
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    push_date(OP_ADVANCE, 4'd0, 5'd0, 12'd0, 16'd0);
    push_date(OP_LOAD, 4'd0, 5'd0, 12'd0, 16'd0);
    push_date(OP_LOAD, 4'd15, 5'd31, 12'd4095, 16'hFFFF);
    push_date(OP_LOAD, 4'd1, 5'd0, 12'd1899, 16'd0);
    push_date(OP_LOAD, 4'd1, 5'd0, 12'd1900, 16'd0);
    push_date(OP_LOAD, 4'd4, 5'd31, 12'd2000, 16'd0);
    push_date(OP_LOAD, 4'd2, 5'd29, 12'd1900, 16'd0);
    push_date(OP_LOAD, 4'd2, 5'd29, 12'd2100, 16'd0);
    push_date(OP_LOAD, 4'd2, 5'd29, 12'd2000, 16'd0);
    push_date(OP_ADVANCE, 4'd15, 5'd31, 12'd4095, 16'd1);
    push_date(OP_LOAD, 4'd2, 5'd28, 12'd2004, 16'd0);
    push_date(OP_ADVANCE, 4'd0, 5'd0, 12'd0, 16'd1);
    push_date(OP_LOAD, 4'd12, 5'd31, 12'd2100, 16'd0);
    // run past the last representable year; the twelfth step overflows
    repeat (12) push_date(OP_ADVANCE, 4'd0, 5'd0, 12'd0, 16'hFFFF);
    push_date(OP_ADVANCE, 4'd0, 5'd0, 12'd0, 16'd1);

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      sel = $urandom_range(0, 19);
      m   = MonthW'($urandom);
      d   = DayW'($urandom);
      y   = YearW'($urandom);
      n   = CountW'($urandom);
      if (sel < 11) begin
        pick = $urandom_range(0, 99);
        if (pick < 10) n = CountW'($urandom_range(0, 2));
        else if (pick < 99) n = CountW'($urandom_range(3, 400));
        push_date(OP_ADVANCE, m, d, y, n);
      end else begin
        m = MonthW'($urandom_range(1, 12));
        y = YearW'($urandom_range(1900, 2100));
        if (sel < 16) begin
          if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 4))
              0:       y = 12'd1900;
              1:       y = 12'd2000;
              2:       y = 12'd2100;
              3:       y = 12'd2096;
              default: y = 12'd2004;
            endcase
          end
          len = date_scoreboard::month_length(m, y);
          d   = $urandom_range(0, 1) ? len - DayW'($urandom_range(0, 2))
                                     : DayW'($urandom_range(1, len));
        end else if (sel == 16) begin
          m = MonthW'($urandom_range(0, 3));
          if (m != 0) m = m + 4'd12;
        end else if (sel == 17) begin
          y = $urandom_range(0, 1) ? YearW'($urandom_range(0, 1899))
                                   : YearW'($urandom_range(2101, 4095));
        end else begin
          len = date_scoreboard::month_length(m, y);
          if (len == DayLast || $urandom_range(0, 3) == 0) d = 5'd0;
          else d = DayW'($urandom_range(len + 1, 31));
        end
        push_date(OP_LOAD, m, d, y, n);
      end
    end
    in_tvalid = 1'b0;

    while (sb.awaited.size() != 0) @(negedge clk);
    repeat (24) @(negedge clk);

    $display("Covered %0d loads (%0d rejected) and %0d advances stepping %0d days",
             sb.loads, sb.rejects, sb.advances, sb.days_stepped);
    $display("Year overflows: %0d, results on 29 February: %0d, cycles: %0d",
             sb.overflows, sb.feb29_seen, cycle_count);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### sim.f
hdl/cdc_pkg.sv
hdl/cdc_seq.sv
hdl/cdc_dpath.sv
hdl/calendar_date_counter.sv
verif/calendar_date_counter_tb.sv
